// ===== design/lprg_pkg.sv =====
// ----------------------------------------------------------------------------
// lprg_pkg
// Shared constants, types and the arctangent table for the lidar point
// range gate and timing core.
// ----------------------------------------------------------------------------
package lprg_pkg;

	localparam int NUM_RINGS    = 32;
	localparam int CORDIC_STEPS = 16;
	// table has 24 entries, extra steps are ignored
	localparam int CSTEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam int RING_W = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;

	localparam int POS_W   = 20;
	localparam int INT_W   = 8;
	localparam int TIME_W  = 63;
	localparam int RSQ_W   = 40;
	localparam int LIM_W   = 19;
	localparam int TPU_W   = 32;
	localparam int AZ_W    = 16;
	localparam int ANG_W   = 32;
	localparam int REL_W   = 40;
	// CORDIC datapath: 21-bit magnitude times gain 1.65 fits 23 bits signed
	localparam int XW      = 23;
	localparam int PROD_W  = AZ_W + TPU_W;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_UNIT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_TM  = 2'd3;
	localparam int CFG_DATA_W = 32;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_POINT = 1'b1;

	// item as it moves through the front pipeline
	typedef struct packed {
		logic              kind;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [POS_W-1:0]  z;
		logic [INT_W-1:0]  inten;
		logic [TIME_W-1:0] tm;
		logic [RING_W-1:0] ring;
		logic [RSQ_W-1:0]  sqx;
		logic [RSQ_W-1:0]  sqy;
		logic [RSQ_W-1:0]  sqz;
		logic [RSQ_W-1:0]  dsq;
		logic [XW-1:0]     cx;
		logic [XW-1:0]     cy;
		logic [ANG_W-1:0]  ang;
		logic              origin;
	} front_rec_t;

	// classified item handed to the back part
	typedef struct packed {
		logic              kind;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [POS_W-1:0]  z;
		logic [INT_W-1:0]  inten;
		logic [RSQ_W-1:0]  dsq;
		logic [TIME_W-1:0] tm;
		logic [RING_W-1:0] ring;
		logic [AZ_W-1:0]   az;
	} back_rec_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// atan(2^-i) in 2^32 units per turn
	function automatic logic [ANG_W-1:0] atan_turn(input logic [4:0] i);
		logic [ANG_W-1:0] r;
		unique case (i)
			5'd0:    r = 32'd536870912;
			5'd1:    r = 32'd316933406;
			5'd2:    r = 32'd167458907;
			5'd3:    r = 32'd85004756;
			5'd4:    r = 32'd42667331;
			5'd5:    r = 32'd21354465;
			5'd6:    r = 32'd10680862;
			5'd7:    r = 32'd5340245;
			5'd8:    r = 32'd2670163;
			5'd9:    r = 32'd1335087;
			5'd10:   r = 32'd667544;
			5'd11:   r = 32'd333772;
			5'd12:   r = 32'd166886;
			5'd13:   r = 32'd83443;
			5'd14:   r = 32'd41722;
			5'd15:   r = 32'd20861;
			5'd16:   r = 32'd10430;
			5'd17:   r = 32'd5215;
			5'd18:   r = 32'd2608;
			5'd19:   r = 32'd1304;
			5'd20:   r = 32'd652;
			5'd21:   r = 32'd326;
			5'd22:   r = 32'd163;
			5'd23:   r = 32'd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/lprg_front.sv =====
// ----------------------------------------------------------------------------
// lprg_front
// Accepts beats, squares the range, gates on min/max range and runs the
// pipelined CORDIC azimuth. Kept points and frame starts go to the queue.
// ----------------------------------------------------------------------------
module lprg_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       kind,
	input  logic [lprg_pkg::TIME_W-1:0] frame_time_ns,
	input  logic [lprg_pkg::POS_W-1:0] pos_x,
	input  logic [lprg_pkg::POS_W-1:0] pos_y,
	input  logic [lprg_pkg::POS_W-1:0] pos_z,
	input  logic [4:0]                 ring_index,
	input  logic [lprg_pkg::TIME_W-1:0] sensor_time_ns,
	input  logic [lprg_pkg::INT_W-1:0] intensity_in,
	input  logic [lprg_pkg::LIM_W-1:0] near_lim_mm,
	input  logic [lprg_pkg::LIM_W-1:0] far_lim_mm,
	input  lprg_pkg::q_stat_t          qst,
	output logic                       push,
	output lprg_pkg::back_rec_t        push_data
);
	import lprg_pkg::*;

	logic             en;
	logic [2*LIM_W-1:0] lo_q, hi_q;
	front_rec_t       in_rec, rec_s1, rec_s2;
	logic             v_s1, v_s2;
	front_rec_t       cord_q [0:CSTEPS-1];
	front_rec_t       c_in   [0:CSTEPS-1];
	front_rec_t       c_nxt  [0:CSTEPS-1];
	logic             cv_q   [0:CSTEPS-1];
	back_rec_t        fin_q;
	logic             fin_v_q;
	logic [POS_W-1:0] ax, ay, az;
	logic [XW-1:0]    xe, ye;
	logic [RSQ_W-1:0] dsq;
	logic             keep;
	logic [ANG_W-1:0] ang_r;
	logic [8:0]       ring_ext;

	// whole front advances unless the queue is full
	assign en       = ~qst.full;
	assign in_ready = en;

	// squared range limits, follow the config registers
	always_ff @(posedge clk) begin
		lo_q <= (2*LIM_W)'(near_lim_mm) * (2*LIM_W)'(near_lim_mm);
		hi_q <= (2*LIM_W)'(far_lim_mm) * (2*LIM_W)'(far_lim_mm);
	end

	// input record: abs values, squares, CORDIC pre-rotation
	always_comb begin
		ax = pos_x[POS_W-1] ? (~pos_x + 1'b1) : pos_x;
		ay = pos_y[POS_W-1] ? (~pos_y + 1'b1) : pos_y;
		az = pos_z[POS_W-1] ? (~pos_z + 1'b1) : pos_z;
		xe = XW'($signed(pos_x));
		ye = XW'($signed(pos_y));
		ring_ext = {4'b0, ring_index};
		in_rec        = '0;
		in_rec.kind   = kind;
		in_rec.x      = pos_x;
		in_rec.y      = pos_y;
		in_rec.z      = pos_z;
		in_rec.inten  = intensity_in;
		in_rec.tm     = (kind == KIND_FRAME) ? frame_time_ns : sensor_time_ns;
		in_rec.ring   = (ring_ext >= 9'(NUM_RINGS)) ? RING_W'(NUM_RINGS - 1)
		                                            : RING_W'(ring_index);
		in_rec.sqx    = RSQ_W'(ax) * RSQ_W'(ax);
		in_rec.sqy    = RSQ_W'(ay) * RSQ_W'(ay);
		in_rec.sqz    = RSQ_W'(az) * RSQ_W'(az);
		in_rec.origin = (pos_x == '0) && (pos_y == '0);
		if (pos_x[POS_W-1]) begin
			in_rec.cx  = -xe;
			in_rec.cy  = -ye;
			in_rec.ang = 32'h8000_0000;
		end else begin
			in_rec.cx  = xe;
			in_rec.cy  = ye;
			in_rec.ang = '0;
		end
	end

	// stage 1: register the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rec_s1 <= in_rec;
		end
	end

	// range gate
	assign dsq  = rec_s1.sqx + rec_s1.sqy + rec_s1.sqz;
	assign keep = (rec_s1.kind == KIND_FRAME) ||
	              ((dsq >= RSQ_W'(lo_q)) && (dsq <= RSQ_W'(hi_q)));

	// stage 2: dropped points become bubbles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 & keep;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rec_s2     <= rec_s1;
			rec_s2.dsq <= dsq;
		end
	end

	// CORDIC vectoring, one step per stage
	for (genvar i = 0; i < CSTEPS; i++) begin : g_cord
		logic signed [XW-1:0] sx, sy;

		if (i == 0) begin : g_first
			assign c_in[i] = rec_s2;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cv_q[i] <= 1'b0;
				end else if (en) begin
					cv_q[i] <= v_s2;
				end
			end
		end else begin : g_next
			assign c_in[i] = cord_q[i-1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cv_q[i] <= 1'b0;
				end else if (en) begin
					cv_q[i] <= cv_q[i-1];
				end
			end
		end

		assign sx = $signed(c_in[i].cx);
		assign sy = $signed(c_in[i].cy);

		always_comb begin
			c_nxt[i] = c_in[i];
			if (sy > 0) begin
				c_nxt[i].cx  = XW'(sx + (sy >>> i));
				c_nxt[i].cy  = XW'(sy - (sx >>> i));
				c_nxt[i].ang = c_in[i].ang + atan_turn(5'(i));
			end else begin
				c_nxt[i].cx  = XW'(sx - (sy >>> i));
				c_nxt[i].cy  = XW'(sy + (sx >>> i));
				c_nxt[i].ang = c_in[i].ang - atan_turn(5'(i));
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cord_q[i] <= c_nxt[i];
			end
		end
	end

	// round the angle to 16 bits, origin gives zero
	assign ang_r = cord_q[CSTEPS-1].ang + 32'h0000_8000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_q <= 1'b0;
		end else if (en) begin
			fin_v_q <= cv_q[CSTEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_q.kind  <= cord_q[CSTEPS-1].kind;
			fin_q.x     <= cord_q[CSTEPS-1].x;
			fin_q.y     <= cord_q[CSTEPS-1].y;
			fin_q.z     <= cord_q[CSTEPS-1].z;
			fin_q.inten <= cord_q[CSTEPS-1].inten;
			fin_q.dsq   <= cord_q[CSTEPS-1].dsq;
			fin_q.tm    <= cord_q[CSTEPS-1].tm;
			fin_q.ring  <= cord_q[CSTEPS-1].ring;
			fin_q.az    <= cord_q[CSTEPS-1].origin ? '0 : ang_r[ANG_W-1:ANG_W-AZ_W];
		end
	end

	assign push      = fin_v_q & en;
	assign push_data = fin_q;

endmodule

// ===== design/lprg_fifo.sv =====
// ----------------------------------------------------------------------------
// lprg_fifo
// Small queue between the front and back parts.
// ----------------------------------------------------------------------------
module lprg_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lprg_pkg::back_rec_t push_data,
	input  logic                pop,
	output lprg_pkg::back_rec_t head,
	output lprg_pkg::q_stat_t   qst
);
	import lprg_pkg::*;

	back_rec_t         mem_q [0:QDEPTH-1];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign qst.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign qst.empty = (cnt_q == '0);
	assign head      = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/lprg_back.sv =====
// ----------------------------------------------------------------------------
// lprg_back
// Per-ring timing: first azimuth, relative time with wrap, frame time add
// and saturation, or the sensor time when selected. Ends in the output register.
// ----------------------------------------------------------------------------
module lprg_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lprg_pkg::back_rec_t         head,
	input  lprg_pkg::q_stat_t           qst,
	output logic                        pop,
	input  logic [lprg_pkg::TPU_W-1:0]  tpu,
	input  logic                        use_sensor,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lprg_pkg::POS_W-1:0]  out_x,
	output logic [lprg_pkg::POS_W-1:0]  out_y,
	output logic [lprg_pkg::POS_W-1:0]  out_z,
	output logic [lprg_pkg::INT_W-1:0]  out_intensity,
	output logic [lprg_pkg::RSQ_W-1:0]  range_squared,
	output logic [lprg_pkg::TIME_W-1:0] point_time_ns
);
	import lprg_pkg::*;

	logic                en;
	logic                seen_q [0:NUM_RINGS-1];
	logic                lrv_q  [0:NUM_RINGS-1];
	logic [AZ_W-1:0]     faz_q  [0:NUM_RINGS-1];
	logic [REL_W-1:0]    lr_q   [0:NUM_RINGS-1];
	logic                ring_op;
	logic                new_ring;
	logic [AZ_W-1:0]     d;

	back_rec_t           rec_s1, rec_s2;
	logic                v_s1, v_s2;
	logic                sens_s1, first_s1, sens_s2, first_s2;
	logic [PROD_W-1:0]   prod_s1;
	logic [REL_W-1:0]    rel_s2;
	logic [TPU_W-1:0]    rel0;
	logic [REL_W-1:0]    lrd, rel;
	logic                upd;
	logic [TIME_W-1:0]   frame_q;
	logic [TIME_W:0]     tsum;
	logic [TIME_W-1:0]   tnow;

	assign en  = ~out_valid | out_ready;
	assign pop = en & ~qst.empty;

	// ring lookup on the head item
	assign ring_op  = pop && (head.kind == KIND_POINT) && !use_sensor;
	assign new_ring = !seen_q[head.ring];
	assign d        = faz_q[head.ring] - head.az;

	// relative time against the last one of the ring
	assign rel0 = prod_s1[PROD_W-1:AZ_W];
	assign lrd  = lrv_q[rec_s1.ring] ? lr_q[rec_s1.ring] : '0;
	assign rel  = (REL_W'(rel0) < lrd) ? (REL_W'(rel0) + REL_W'(tpu)) : REL_W'(rel0);
	assign upd  = en && v_s1 && (rec_s1.kind == KIND_POINT) && !sens_s1 && !first_s1;

	// valid bits; a frame start clears everything and wins over a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_RINGS; r++) begin
				seen_q[r] <= 1'b0;
				lrv_q[r]  <= 1'b0;
			end
		end else begin
			if (ring_op && new_ring) begin
				seen_q[head.ring] <= 1'b1;
			end
			if (upd) begin
				lrv_q[rec_s1.ring] <= 1'b1;
			end
			if (pop && (head.kind == KIND_FRAME)) begin
				for (int r = 0; r < NUM_RINGS; r++) begin
					seen_q[r] <= 1'b0;
					lrv_q[r]  <= 1'b0;
				end
			end
		end
	end

	// per-ring data
	always_ff @(posedge clk) begin
		if (ring_op && new_ring) begin
			faz_q[head.ring] <= head.az;
		end
		if (upd) begin
			lr_q[rec_s1.ring] <= rel;
		end
	end

	// stage valids and frame time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
			frame_q   <= '0;
		end else if (en) begin
			v_s1      <= pop;
			v_s2      <= v_s1;
			out_valid <= v_s2 && (rec_s2.kind == KIND_POINT);
			if (v_s2 && (rec_s2.kind == KIND_FRAME)) begin
				frame_q <= rec_s2.tm;
			end
		end
	end

	// time of the point
	assign tsum = {1'b0, frame_q} + (TIME_W+1)'(rel_s2);
	always_comb begin
		if (sens_s2) begin
			tnow = rec_s2.tm;
		end else if (first_s2) begin
			tnow = '0;
		end else if (tsum[TIME_W]) begin
			tnow = '1;
		end else begin
			tnow = tsum[TIME_W-1:0];
		end
	end

	// payload stages and output register
	always_ff @(posedge clk) begin
		if (en) begin
			rec_s1        <= head;
			sens_s1       <= use_sensor;
			first_s1      <= new_ring;
			prod_s1       <= PROD_W'(d) * PROD_W'(tpu);
			rec_s2        <= rec_s1;
			sens_s2       <= sens_s1;
			first_s2      <= first_s1;
			rel_s2        <= rel;
			out_x         <= rec_s2.x;
			out_y         <= rec_s2.y;
			out_z         <= rec_s2.z;
			out_intensity <= rec_s2.inten;
			range_squared <= rec_s2.dsq;
			point_time_ns <= tnow;
		end
	end

endmodule

// ===== design/lidar_point_range_gate_and_timing_core.sv =====
// ----------------------------------------------------------------------------
// lidar_point_range_gate_and_timing_core
// Range gate and azimuth based timestamping of lidar points.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid / in_ready     | kind, times, pos, ring, intensity
//   out     | output    | out_valid / out_ready   | pos, intensity, range, time
//   cfg     | input     | cfg_we                  | cfg_index, cfg_data
//
// One beat per cycle in and out while neither side stalls. The front pipeline
// registers the beat, gates on range and runs the CORDIC, one step per stage;
// then the queue and the back part (lookup and multiply, wrap, output register).
// Reset clears all ring state at once; no clearing pass.
// The front stalls only when the queue is full; the back stalls on out_ready.
// ----------------------------------------------------------------------------
module lidar_point_range_gate_and_timing_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lprg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lprg_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [lprg_pkg::TIME_W-1:0]       frame_time_ns,
	input  logic [lprg_pkg::POS_W-1:0]        pos_x,
	input  logic [lprg_pkg::POS_W-1:0]        pos_y,
	input  logic [lprg_pkg::POS_W-1:0]        pos_z,
	input  logic [4:0]                        ring_index,
	input  logic [lprg_pkg::TIME_W-1:0]       sensor_time_ns,
	input  logic [lprg_pkg::INT_W-1:0]        intensity_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lprg_pkg::POS_W-1:0]        out_x,
	output logic [lprg_pkg::POS_W-1:0]        out_y,
	output logic [lprg_pkg::POS_W-1:0]        out_z,
	output logic [lprg_pkg::INT_W-1:0]        out_intensity,
	output logic [lprg_pkg::RSQ_W-1:0]        range_squared,
	output logic [lprg_pkg::TIME_W-1:0]       point_time_ns
);
	import lprg_pkg::*;

	logic [LIM_W-1:0] min_q, max_q;
	logic [TPU_W-1:0] tpu_q;
	logic             sens_q;
	logic             push, pop;
	back_rec_t        push_data, head;
	q_stat_t          qst;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= '0;
			max_q  <= '1;
			tpu_q  <= TPU_W'(1526);
			sens_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_RANGE: min_q  <= cfg_data[LIM_W-1:0];
				CFG_MAX_RANGE: max_q  <= cfg_data[LIM_W-1:0];
				CFG_TIME_UNIT: tpu_q  <= cfg_data[TPU_W-1:0];
				CFG_SENSOR_TM: sens_q <= cfg_data[0];
				default:       sens_q <= sens_q;
			endcase
		end
	end

	lprg_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.frame_time_ns  (frame_time_ns),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.ring_index     (ring_index),
		.sensor_time_ns (sensor_time_ns),
		.intensity_in   (intensity_in),
		.near_lim_mm    (min_q),
		.far_lim_mm     (max_q),
		.qst            (qst),
		.push           (push),
		.push_data      (push_data)
	);

	lprg_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qst       (qst)
	);

	lprg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.qst           (qst),
		.pop           (pop),
		.tpu           (tpu_q),
		.use_sensor    (sens_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_z         (out_z),
		.out_intensity (out_intensity),
		.range_squared (range_squared),
		.point_time_ns (point_time_ns)
	);

endmodule

// ===== design/lprg_checker.sv =====
// ----------------------------------------------------------------------------
// lprg_checker
// Port level checks on the core, attached by bind.
// ----------------------------------------------------------------------------
module lprg_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [lprg_pkg::RSQ_W-1:0]        range_squared,
	input logic [lprg_pkg::TIME_W-1:0]       point_time_ns
);
	logic seen_in_q;

	// any beat taken since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_in_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			seen_in_q <= 1'b1;
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(range_squared)
		&& $stable(point_time_ns))
		else $error("output beat changed while stalled");

	// no result right after reset release
	a_rst_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

	// results only follow accepted input beats
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_in_q)
		else $error("result without any input beat");

endmodule

bind lidar_point_range_gate_and_timing_core lprg_checker u_lprg_checker (.*);
